@@ src/cau_pkg.sv @@
// Shared types and constants of the complex arithmetic unit.
`default_nettype none
package cau_pkg;
  localparam int DATA_W = 16;
  localparam int PROD_W = 2 * DATA_W;
  localparam int TERM_W = PROD_W + 1;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_MAG = 3'd4;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] NEG_MAX = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {K_NONE, K_ADD, K_SUB, K_MUL, K_DIV, K_MAG} kind_t;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_re;
    logic signed [DATA_W-1:0] res_im;
    logic [1:0]               status;
  } out_req_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [TERM_W-1:0] t0;
    logic signed [TERM_W-1:0] t1;
    logic signed [TERM_W-1:0] t2;
    logic signed [TERM_W-1:0] t3;
    logic                     neg1;
    logic                     neg3;
    logic [PROD_W-1:0]        sq0;
    logic [PROD_W-1:0]        sq1;
  } term_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;
endpackage
`default_nettype wire

@@ src/cau_front.sv @@
// Front end: accept a request, decode the operation and form the products.
`default_nettype none
module cau_front (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  cau_pkg::in_req_t   in_data,
  input  cau_pkg::q_stat_t   q_stat,
  output logic               push,
  output cau_pkg::term_t     push_data
);
  localparam int W  = cau_pkg::DATA_W;
  localparam int PW = cau_pkg::PROD_W;
  localparam int TW = cau_pkg::TERM_W;

  logic signed [W-1:0]  ar, ai, br, bi, s4, s5;
  logic signed [PW-1:0] m0, m1, m2, m3, m4, m5;
  logic                 f_valid_r;
  logic                 f_en;
  cau_pkg::term_t       f_data_r, f_data_nxt;

  assign ar = in_data.a_re;
  assign ai = in_data.a_im;
  assign br = in_data.b_re;
  assign bi = in_data.b_im;
  assign s4 = (in_data.mode == cau_pkg::MODE_MAG) ? ar : br;
  assign s5 = (in_data.mode == cau_pkg::MODE_MAG) ? ai : bi;
  assign m0 = ar * br;
  assign m1 = ai * bi;
  assign m2 = ar * bi;
  assign m3 = ai * br;
  assign m4 = s4 * s4;
  assign m5 = s5 * s5;

  assign f_en      = !f_valid_r || !q_stat.full;
  assign in_stall  = !f_en;
  assign push      = f_valid_r && !q_stat.full;
  assign push_data = f_data_r;

  always_comb begin
    f_data_nxt = '0;
    f_data_nxt.kind = cau_pkg::K_NONE;
    f_data_nxt.sq0 = PW'(m4);
    f_data_nxt.sq1 = PW'(m5);
    case (in_data.mode)
      cau_pkg::MODE_ADD: begin
        f_data_nxt.kind = cau_pkg::K_ADD;
        f_data_nxt.t0 = TW'(ar);
        f_data_nxt.t1 = TW'(br);
        f_data_nxt.t2 = TW'(ai);
        f_data_nxt.t3 = TW'(bi);
      end
      cau_pkg::MODE_SUB: begin
        f_data_nxt.kind = cau_pkg::K_SUB;
        f_data_nxt.t0 = TW'(ar);
        f_data_nxt.t1 = TW'(br);
        f_data_nxt.t2 = TW'(ai);
        f_data_nxt.t3 = TW'(bi);
        f_data_nxt.neg1 = 1'b1;
        f_data_nxt.neg3 = 1'b1;
      end
      cau_pkg::MODE_MUL: begin
        f_data_nxt.kind = cau_pkg::K_MUL;
        f_data_nxt.t0 = TW'(m0);
        f_data_nxt.t1 = TW'(m1);
        f_data_nxt.t2 = TW'(m2);
        f_data_nxt.t3 = TW'(m3);
        f_data_nxt.neg1 = 1'b1;
      end
      cau_pkg::MODE_DIV: begin
        f_data_nxt.kind = cau_pkg::K_DIV;
        f_data_nxt.t0 = TW'(m0);
        f_data_nxt.t1 = TW'(m1);
        f_data_nxt.t2 = TW'(m3);
        f_data_nxt.t3 = TW'(m2);
        f_data_nxt.neg3 = 1'b1;
      end
      cau_pkg::MODE_MAG: begin
        f_data_nxt.kind = cau_pkg::K_MAG;
      end
      default: begin
        f_data_nxt.kind = cau_pkg::K_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (f_en) begin
      f_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_en && in_valid) begin
      f_data_r <= f_data_nxt;
    end
  end
endmodule
`default_nettype wire

@@ src/cau_queue.sv @@
// Short request queue between the front end and the back end.
`default_nettype none
module cau_queue (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  cau_pkg::term_t    push_data,
  input  wire               pop,
  output cau_pkg::term_t    pop_data,
  output cau_pkg::q_stat_t  q_stat
);
  localparam int QD = cau_pkg::QUEUE_DEPTH;
  localparam int AW = $clog2(QD);

  cau_pkg::term_t mem_r [QD];
  logic [AW-1:0]  wr_r, rd_r;
  logic [AW:0]    cnt_r;
  logic           push_ok, pop_ok;

  assign q_stat.full  = (cnt_r == (AW+1)'(QD));
  assign q_stat.empty = (cnt_r == '0);
  assign push_ok      = push && !q_stat.full;
  assign pop_ok       = pop && !q_stat.empty;
  assign pop_data     = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) begin
        wr_r <= wr_r + AW'(1);
      end
      if (pop_ok) begin
        rd_r <= rd_r + AW'(1);
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + (AW+1)'(1);
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_r] <= push_data;
    end
  end

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    push_ok && !pop_ok |=> cnt_r == $past(cnt_r) + (AW+1)'(1))
    else $error("queue count did not advance on push");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(QD))
    else $error("queue count beyond depth");
endmodule
`default_nettype wire

@@ src/cau_back.sv @@
// Back end: sums, pipelined divider and square root, saturation, output register.
`default_nettype none
module cau_back #(
  parameter int FRAC_BITS = 8
) (
  input  wire               clk,
  input  wire               rst_n,
  input  cau_pkg::q_stat_t  q_stat,
  input  cau_pkg::term_t    pop_data,
  output logic              pop,
  output logic              out_valid,
  input  wire               out_stall,
  output cau_pkg::out_req_t out_data
);
  localparam int W  = cau_pkg::DATA_W;
  localparam int SW = cau_pkg::TERM_W;
  localparam int MW = SW;
  localparam int DW = cau_pkg::PROD_W;
  localparam int NW = MW + FRAC_BITS;
  localparam int L  = NW;

  typedef struct packed {
    cau_pkg::kind_t kind;
    logic           neg_r;
    logic           neg_i;
    logic [MW-1:0]  mag_r;
    logic [MW-1:0]  mag_i;
    logic [DW-1:0]  den;
    logic [DW:0]    rem_r;
    logic [DW:0]    rem_i;
    logic [NW-1:0]  q_r;
    logic [NW-1:0]  q_i;
    logic [W-1:0]   root;
    logic [W+1:0]   srem;
  } stg_t;

  function automatic logic [W:0] clamp(input logic neg, input logic [NW-1:0] m);
    logic [W:0] r;
    if (!neg) begin
      if (m > NW'(cau_pkg::POS_MAX)) begin
        r = {1'b1, cau_pkg::POS_MAX};
      end else begin
        r = {1'b0, m[W-1:0]};
      end
    end else begin
      if (m > NW'(cau_pkg::NEG_MAX)) begin
        r = {1'b1, cau_pkg::NEG_MAX};
      end else begin
        r = {1'b0, W'(~m[W-1:0] + W'(1))};
      end
    end
    return r;
  endfunction

  stg_t              st_r   [0:L];
  stg_t              st_nxt [0:L];
  logic              v_r    [0:L];
  logic              adv;
  logic              out_valid_r;
  cau_pkg::out_req_t out_r, out_nxt;
  logic signed [SW-1:0] h0, h1, h2, h3, sr, si;

  assign adv       = !out_valid_r || !out_stall;
  assign pop       = adv && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    h0 = pop_data.t0;
    h1 = pop_data.t1;
    h2 = pop_data.t2;
    h3 = pop_data.t3;
    sr = h0 + (pop_data.neg1 ? -h1 : h1);
    si = h2 + (pop_data.neg3 ? -h3 : h3);
    if (pop_data.kind == cau_pkg::K_MUL) begin
      sr = sr >>> FRAC_BITS;
      si = si >>> FRAC_BITS;
    end
    st_nxt[0] = '0;
    st_nxt[0].kind  = pop_data.kind;
    st_nxt[0].neg_r = sr[SW-1];
    st_nxt[0].neg_i = si[SW-1];
    st_nxt[0].mag_r = sr[SW-1] ? MW'(-sr) : MW'(sr);
    st_nxt[0].mag_i = si[SW-1] ? MW'(-si) : MW'(si);
    st_nxt[0].den   = DW'(pop_data.sq0 + pop_data.sq1);
  end

  for (genvar k = 1; k <= L; k++) begin : g_stage
    localparam int PI = (k <= W) ? 2 * (W - k) : 0;
    logic [NW-1:0] n_r, n_i;
    logic [DW:0]   tr_r, tr_i;
    always_comb begin
      n_r  = NW'(st_r[k-1].mag_r) << FRAC_BITS;
      n_i  = NW'(st_r[k-1].mag_i) << FRAC_BITS;
      tr_r = {st_r[k-1].rem_r[DW-1:0], n_r[NW-k]};
      tr_i = {st_r[k-1].rem_i[DW-1:0], n_i[NW-k]};
      st_nxt[k] = st_r[k-1];
      if (tr_r >= {1'b0, st_r[k-1].den}) begin
        st_nxt[k].rem_r = tr_r - {1'b0, st_r[k-1].den};
        st_nxt[k].q_r   = {st_r[k-1].q_r[NW-2:0], 1'b1};
      end else begin
        st_nxt[k].rem_r = tr_r;
        st_nxt[k].q_r   = {st_r[k-1].q_r[NW-2:0], 1'b0};
      end
      if (tr_i >= {1'b0, st_r[k-1].den}) begin
        st_nxt[k].rem_i = tr_i - {1'b0, st_r[k-1].den};
        st_nxt[k].q_i   = {st_r[k-1].q_i[NW-2:0], 1'b1};
      end else begin
        st_nxt[k].rem_i = tr_i;
        st_nxt[k].q_i   = {st_r[k-1].q_i[NW-2:0], 1'b0};
      end
      if (k <= W) begin
        st_nxt[k].srem = {st_r[k-1].srem[W-1:0],
                          st_r[k-1].den[PI + 1], st_r[k-1].den[PI]};
        if (st_nxt[k].srem >= {st_r[k-1].root, 2'b01}) begin
          st_nxt[k].srem = st_nxt[k].srem - {st_r[k-1].root, 2'b01};
          st_nxt[k].root = {st_r[k-1].root[W-2:0], 1'b1};
        end else begin
          st_nxt[k].root = {st_r[k-1].root[W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  always_comb begin
    logic [W:0] cr, ci;
    cr = '0;
    ci = '0;
    out_nxt = '0;
    out_nxt.status = cau_pkg::ST_OK;
    case (st_r[L].kind)
      cau_pkg::K_ADD, cau_pkg::K_SUB, cau_pkg::K_MUL: begin
        cr = clamp(st_r[L].neg_r, NW'(st_r[L].mag_r));
        ci = clamp(st_r[L].neg_i, NW'(st_r[L].mag_i));
      end
      cau_pkg::K_DIV: begin
        if (st_r[L].den != '0) begin
          cr = clamp(st_r[L].neg_r, st_r[L].q_r);
          ci = clamp(st_r[L].neg_i, st_r[L].q_i);
        end else begin
          out_nxt.status = cau_pkg::ST_DZ;
        end
      end
      cau_pkg::K_MAG: begin
        cr = clamp(1'b0, NW'(st_r[L].root));
      end
      default: begin
        cr = '0;
      end
    endcase
    out_nxt.res_re = cr[W-1:0];
    out_nxt.res_im = ci[W-1:0];
    if (cr[W] || ci[W]) begin
      out_nxt.status = cau_pkg::ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0]      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r[0]      <= !q_stat.empty;
      out_valid_r <= v_r[L];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= st_nxt[0];
      if (v_r[L]) begin
        out_r <= out_nxt;
      end
    end
  end

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == cau_pkg::ST_DZ |-> out_r.res_re == '0 && out_r.res_im == '0)
    else $error("divide-by-zero result not zero");
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == cau_pkg::ST_SAT |->
      out_r.res_re == cau_pkg::POS_MAX || out_r.res_re == cau_pkg::NEG_MAX ||
      out_r.res_im == cau_pkg::POS_MAX || out_r.res_im == cau_pkg::NEG_MAX)
    else $error("saturated result not at a limit");
endmodule
`default_nettype wire

@@ src/complex_arithmetic_unit.sv @@
// Top level of the complex arithmetic unit.
// Takes one request per cycle while in_stall is low and returns one result per request, in
// order. A request passes a front register that forms all products, a four-entry queue,
// and a back pipeline of 2*16+1+FRAC_BITS restoring-divider stages (the square root runs
// in the first 16 of them) plus an entry stage and the output register. The back pipeline
// holds as a whole while a presented result is stalled; the queue absorbs the front end
// meanwhile.
`default_nettype none
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = 8
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  cau_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output cau_pkg::out_req_t  out_data
);
  cau_pkg::q_stat_t q_stat;
  cau_pkg::term_t   push_data, pop_data;
  logic             push, pop;

  cau_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  cau_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );
endmodule
`default_nettype wire
